FILE: hdl/vmt_pkg.sv
`default_nettype none
package vmt_pkg;

  // vertex and coefficient formats (signed Q8.8)
  localparam int VEC_N     = 4;
  localparam int DATA_W    = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_BITS = 8;

  // saturation limits of a 16-bit signed result
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;
  localparam int NEG_LIM = 32768;

  localparam logic [DATA_W-1:0] SAT_MAX_WORD = 16'h7fff;
  localparam logic [DATA_W-1:0] SAT_MIN_WORD = 16'h8000;
  localparam logic [DATA_W-1:0] ONE_Q88      = 16'h0100;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VEC_N * COEF_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE_MODE = 3'd4;

  // identity matrix, row 3 first
  localparam logic [VEC_N-1:0][CFG_DATA_W-1:0] COEF_RST = {
    64'h0100_0000_0000_0000,
    64'h0000_0100_0000_0000,
    64'h0000_0000_0100_0000,
    64'h0000_0000_0000_0100
  };

  // divider: (|e| << 8) / |w|, restoring, several quotient bits per stage
  localparam int DIV_NUM_W  = DATA_W + FRAC_BITS;
  localparam int DIV_DEN_W  = DATA_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  // per-vertex side data that travels next to the divider lanes
  typedef struct packed {
    logic [VEC_N-1:0][DATA_W-1:0] e;
    logic [VEC_N-2:0]             neg;
    logic                         zw;
    logic                         clip;
  } side_t;

endpackage
`default_nettype wire

FILE: hdl/vmt_stream_if.sv
`default_nettype none

// input vertex channel
interface vmt_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_z;
  logic signed [15:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

// transformed vertex channel
interface vmt_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;
  logic              saturated;
  logic              zero_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, output zero_w, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, input zero_w, output ready);
endinterface

`default_nettype wire

FILE: hdl/vmt_div_lane.sv
`default_nettype none
module vmt_div_lane import vmt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire div_req_t             req,
  output logic [DIV_NUM_W-1:0]      quo
);

  // nq holds the dividend bits still to consume, quotient bits shift in at the bottom
  logic [DIV_NUM_W-1:0] nq_r  [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [DIV_STAGES];

  // capture stage
  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= req.num;
      rem_r[0] <= '0;
      den_r[0] <= req.den;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_NUM_W-1:0] nq_nxt;
    logic [DIV_DEN_W-1:0] rem_nxt;

    // DIV_STEPS restoring steps
    always_comb begin
      logic [DIV_DEN_W:0] trial;
      nq_nxt  = nq_r[s];
      rem_nxt = rem_r[s];
      trial   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        trial  = {rem_nxt, nq_nxt[DIV_NUM_W-1]};
        nq_nxt = {nq_nxt[DIV_NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_r[s]}) begin
          trial     = trial - {1'b0, den_r[s]};
          nq_nxt[0] = 1'b1;
        end
        rem_nxt = trial[DIV_DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[s+1] <= nq_nxt;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          den_r[s+1] <= den_r[s];
        end
      end
    end
  end

  assign quo = nq_r[DIV_STAGES];

endmodule
`default_nettype wire

FILE: hdl/vertex_matrix_transform.sv
// Vertex row times 4x4 Q8.8 matrix, with optional divide by the result w.
// Pipeline: products, column sums, divider capture, six divider stages, then the result register.
// Throughput: one vertex per cycle while the output is not stalled; 16 multipliers
//   work in parallel, and each lane has a divider of six 4-bit restoring stages.
// A stall at the output holds the whole pipeline in place.
// Reset (rst_n low, synchronous) drops words in flight, loads identity, divide off.
`default_nettype none
module vertex_matrix_transform import vmt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vmt_in_if.sink                     in_ch,
  vmt_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  function automatic logic [DATA_W-1:0] mag16(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] ext;
    ext = (DATA_W+1)'(v);
    if (ext < 0) ext = -ext;
    return ext[DATA_W-1:0];
  endfunction

  // configuration registers
  logic [VEC_N-1:0][CFG_DATA_W-1:0] coef_r;
  logic                             div_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r     <= COEF_RST;
      div_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_ROW0:   coef_r[0]  <= cfg_wdata;
        CFG_COEF_ROW1:   coef_r[1]  <= cfg_wdata;
        CFG_COEF_ROW2:   coef_r[2]  <= cfg_wdata;
        CFG_COEF_ROW3:   coef_r[3]  <= cfg_wdata;
        CFG_DIVIDE_MODE: div_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: all stages move unless the output word is stuck
  logic adv;
  logic out_vld_r;
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage A: sixteen products
  logic signed [DATA_W-1:0] vin [VEC_N];
  logic signed [PROD_W-1:0] prod_nxt [VEC_N][VEC_N];
  logic signed [PROD_W-1:0] prod_r   [VEC_N][VEC_N];
  logic                     vld_a_r;

  assign vin[0] = in_ch.in_x;
  assign vin[1] = in_ch.in_y;
  assign vin[2] = in_ch.in_z;
  assign vin[3] = in_ch.in_w;

  always_comb begin
    for (int k = 0; k < VEC_N; k++) begin
      for (int j = 0; j < VEC_N; j++) begin
        prod_nxt[k][j] = vin[k] * $signed(coef_r[k][j*COEF_W +: COEF_W]);
      end
    end
  end

  // stage B: column sums, floor shift, saturate
  logic signed [DATA_W-1:0] e_nxt [VEC_N];
  logic signed [DATA_W-1:0] e_r   [VEC_N];
  logic                     clip_b_nxt;
  logic                     clip_b_r;
  logic                     vld_b_r;

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] sh;
    clip_b_nxt = 1'b0;
    for (int j = 0; j < VEC_N; j++) begin
      acc = '0;
      for (int k = 0; k < VEC_N; k++) begin
        acc = acc + ACC_W'(prod_r[k][j]);
      end
      sh = acc >>> FRAC_BITS;
      if (sh > SAT_MAX) begin
        e_nxt[j]   = SAT_MAX_WORD;
        clip_b_nxt = 1'b1;
      end else if (sh < SAT_MIN) begin
        e_nxt[j]   = SAT_MIN_WORD;
        clip_b_nxt = 1'b1;
      end else begin
        e_nxt[j] = sh[DATA_W-1:0];
      end
    end
  end

  // divider requests and side data for the capture stage
  div_req_t             req [VEC_N-1];
  side_t                side_nxt;
  side_t                sb_r   [DIV_STAGES+1];
  logic                 vld_d_r[DIV_STAGES+1];
  logic [DIV_NUM_W-1:0] quo    [VEC_N-1];

  always_comb begin
    for (int j = 0; j < VEC_N - 1; j++) begin
      req[j].num      = {mag16(e_r[j]), {FRAC_BITS{1'b0}}};
      req[j].den      = mag16(e_r[VEC_N-1]);
      side_nxt.neg[j] = e_r[j][DATA_W-1] ^ e_r[VEC_N-1][DATA_W-1];
    end
    for (int j = 0; j < VEC_N; j++) begin
      side_nxt.e[j] = e_r[j];
    end
    side_nxt.zw   = (e_r[VEC_N-1] == '0);
    side_nxt.clip = clip_b_r;
  end

  for (genvar j = 0; j < VEC_N - 1; j++) begin : g_lane
    vmt_div_lane u_div (
      .clk (clk),
      .en  (adv),
      .req (req[j]),
      .quo (quo[j])
    );
  end

  // final stage: sign, saturate, zero-w and mode select
  logic [DATA_W-1:0] res_nxt [VEC_N];
  logic              sat_nxt;
  logic              zw_nxt;
  side_t             sd;

  assign sd = sb_r[DIV_STAGES];

  always_comb begin
    logic [DIV_NUM_W-1:0] negq;
    sat_nxt = sd.clip;
    zw_nxt  = 1'b0;
    negq    = '0;
    for (int j = 0; j < VEC_N; j++) begin
      res_nxt[j] = sd.e[j];
    end
    if (div_mode_r) begin
      if (sd.zw) begin
        zw_nxt = 1'b1;
        for (int j = 0; j < VEC_N; j++) begin
          res_nxt[j] = '0;
        end
      end else begin
        res_nxt[VEC_N-1] = ONE_Q88;
        for (int j = 0; j < VEC_N - 1; j++) begin
          negq = -quo[j];
          if (sd.neg[j]) begin
            if (quo[j] > NEG_LIM) begin
              res_nxt[j] = SAT_MIN_WORD;
              sat_nxt    = 1'b1;
            end else begin
              res_nxt[j] = negq[DATA_W-1:0];
            end
          end else begin
            if (quo[j] > SAT_MAX) begin
              res_nxt[j] = SAT_MAX_WORD;
              sat_nxt    = 1'b1;
            end else begin
              res_nxt[j] = quo[j][DATA_W-1:0];
            end
          end
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      out_vld_r <= 1'b0;
      for (int s = 0; s <= DIV_STAGES; s++) vld_d_r[s] <= 1'b0;
    end else if (adv) begin
      vld_a_r    <= in_ch.valid;
      vld_b_r    <= vld_a_r;
      vld_d_r[0] <= vld_b_r;
      for (int s = 0; s < DIV_STAGES; s++) vld_d_r[s+1] <= vld_d_r[s];
      out_vld_r  <= vld_d_r[DIV_STAGES];
    end
  end

  // payload registers
  logic [DATA_W-1:0] res_r [VEC_N];
  logic              sat_r;
  logic              zw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod_nxt;
      e_r      <= e_nxt;
      clip_b_r <= clip_b_nxt;
      sb_r[0]  <= side_nxt;
      for (int s = 0; s < DIV_STAGES; s++) sb_r[s+1] <= sb_r[s];
      res_r    <= res_nxt;
      sat_r    <= sat_nxt;
      zw_r     <= zw_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_x     = res_r[0];
  assign out_ch.out_y     = res_r[1];
  assign out_ch.out_z     = res_r[2];
  assign out_ch.out_w     = res_r[3];
  assign out_ch.saturated = sat_r;
  assign out_ch.zero_w    = zw_r;

  // a zero-w word carries all-zero elements
  a_zero_w_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && zw_r |-> res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0
                          && res_r[3] == '0)
    else $error("zero_w word with nonzero elements");

  // an accepted word lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_a_r)
    else $error("accepted word not captured");

  // input backpressure only while the output word waits
  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_vld_r && !out_ch.ready)
    else $error("input stalled without output stall");

  // a held pipeline keeps its last stage
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_d_r[DIV_STAGES] == $past(vld_d_r[DIV_STAGES]))
    else $error("stalled stage changed");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
  import vmt_pkg::*;

  localparam int DUT_LATENCY  = 10;
  localparam int SETTLE_CYCLES = 2 * DUT_LATENCY + 4;
  localparam int PHASE_ITEMS  = 90;

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_DIVIDE_MODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = {CFG_IDX_W{1'b1}};

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic [CFG_DATA_W-1:0] matrix_t [VEC_N];

  typedef struct {
    elem_t v [VEC_N];
  } vertex_t;

  typedef struct {
    elem_t v [VEC_N];
    bit    saturated;
    bit    zero_w;
  } result_t;

  typedef enum {
    MAT_IDENTITY, MAT_PERSPECTIVE, MAT_SMALL, MAT_FULL, MAT_ZERO, MAT_MAX
  } matrix_style_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vmt_in_if  in_ch ();
  vmt_out_if out_ch ();

  vertex_matrix_transform dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // local copy of the register file
  logic [CFG_DATA_W-1:0] coef_model [VEC_N];
  bit                    divide_model;

  result_t pending_results [$];
  int unsigned error_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned reg_writes    = 0;
  int unsigned clip_seen     = 0;
  int unsigned zero_w_seen   = 0;

  bit          in_idle_en  = 1'b0;
  bit          out_stall_en = 1'b0;
  int unsigned long_hold_cycles = 0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp16(longint val, inout bit clip);
    if (val > SAT_MAX) begin
      clip = 1'b1;
      return SAT_MAX;
    end
    if (val < SAT_MIN) begin
      clip = 1'b1;
      return SAT_MIN;
    end
    return val;
  endfunction

  function automatic result_t transform_vertex(vertex_t vin);
    result_t r;
    longint  acc;
    longint  e [VEC_N];
    longint  w;
    bit      clip;
    clip     = 1'b0;
    r.zero_w = 1'b0;
    // row vector times matrix, floor shift back to Q8.8
    for (int j = 0; j < VEC_N; j++) begin
      acc = 0;
      for (int k = 0; k < VEC_N; k++)
        acc += longint'(vin.v[k]) *
               longint'($signed(coef_model[k][COEF_W*j +: COEF_W]));
      e[j] = clamp16(acc >>> FRAC_BITS, clip);
    end
    // perspective divide, quotient truncates toward zero
    if (divide_model) begin
      w = e[VEC_N-1];
      if (w == 0) begin
        r.zero_w = 1'b1;
        for (int j = 0; j < VEC_N; j++) e[j] = 0;
      end else begin
        for (int j = 0; j < VEC_N; j++)
          e[j] = clamp16((e[j] <<< FRAC_BITS) / w, clip);
      end
    end
    for (int j = 0; j < VEC_N; j++) r.v[j] = e[j][DATA_W-1:0];
    r.saturated = clip;
    return r;
  endfunction

  function automatic void reset_model();
    for (int r = 0; r < VEC_N; r++) coef_model[r] = COEF_RST[r];
    divide_model = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic vertex_t mk_vertex(elem_t x, elem_t y, elem_t z, elem_t w);
    vertex_t v;
    v.v[0] = x;
    v.v[1] = y;
    v.v[2] = z;
    v.v[3] = w;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(elem_t c0, elem_t c1,
                                                     elem_t c2, elem_t c3);
    return {c3, c2, c1, c0};
  endfunction

  // mostly moderate values, some full range, a few extremes
  function automatic elem_t rand_elem();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return elem_t'($urandom);
    if (pick < 9) return elem_t'(int'($urandom_range(0, 4096)) - 2048);
    case ($urandom_range(0, 4))
      0:       return elem_t'(SAT_MAX);
      1:       return elem_t'(SAT_MIN);
      2:       return elem_t'(0);
      3:       return elem_t'(-1);
      default: return elem_t'(ONE_Q88);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    return mk_vertex(rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endfunction

  function automatic matrix_t build_matrix(matrix_style_t style);
    matrix_t m;
    elem_t   inv_dist;
    for (int r = 0; r < VEC_N; r++) begin
      case (style)
        MAT_SMALL:
          for (int j = 0; j < VEC_N; j++)
            m[r][COEF_W*j +: COEF_W] = elem_t'(int'($urandom_range(0, 1024)) - 512);
        MAT_FULL: m[r] = {$urandom, $urandom};
        MAT_ZERO: m[r] = '0;
        MAT_MAX:  m[r] = {VEC_N{SAT_MAX_WORD}};
        default:  m[r] = COEF_RST[r];
      endcase
    end
    // identity with w taken from z scaled by 1/distance
    if (style == MAT_PERSPECTIVE) begin
      inv_dist = elem_t'($urandom_range(1, 256));
      m[2] = pack_row('0, '0, ONE_Q88, inv_dist);
      m[3] = '0;
    end
    return m;
  endfunction

  // one word on the vertex channel, with an occasional idle burst ahead of it
  task automatic send_vertex(vertex_t v);
    int unsigned gap;
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= v.v[0];
    in_ch.in_y  <= v.v[1];
    in_ch.in_z  <= v.v[2];
    in_ch.in_w  <= v.v[3];
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(transform_vertex(v));
    words_sent++;
  endtask

  // stop offering words and let the pipeline empty out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_we is left high; cfg_release drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx <= CFG_COEF_ROW3) coef_model[idx] = data;
    else if (idx == CFG_DIVIDE_MODE) divide_model = data[0];
    reg_writes++;
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // full register set; junk in the upper divide_mode bits must be dropped
  task automatic program_regs(matrix_t m, bit div);
    for (int r = 0; r < VEC_N; r++)
      write_reg(CFG_IDX_W'(CFG_COEF_ROW0 + r), m[r]);
    write_reg(CFG_DIVIDE_MODE, ({$urandom, $urandom} & ~64'd1) | CFG_DATA_W'(div));
    cfg_release();
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual x=%0d y=%0d z=%0d w=%0d",
                 $time, out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("out_x", want.v[0], out_ch.out_x);
        compare_field("out_y", want.v[1], out_ch.out_y);
        compare_field("out_z", want.v[2], out_ch.out_z);
        compare_field("out_w", want.v[3], out_ch.out_w);
        compare_field("saturated", want.saturated, out_ch.saturated);
        compare_field("zero_w", want.zero_w, out_ch.zero_w);
        clip_seen   += want.saturated;
        zero_w_seen += want.zero_w;
        words_checked++;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  initial begin : out_ready_driver
    int unsigned hold;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles != 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (out_stall_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 11);
        repeat (hold) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values: identity, no divide; field extremes and alternating bits
  task automatic test_identity_extremes();
    send_vertex(mk_vertex(16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff));
    send_vertex(mk_vertex(16'sh8000, 16'sh7fff, 16'sh0001, 16'sh0100));
    send_vertex(mk_vertex(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    send_vertex(mk_vertex(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00));
    wait_drained();
  endtask

  // clipping in both directions and floor rounding of negative products
  task automatic test_multiply_saturation();
    matrix_t m;
    for (int r = 0; r < VEC_N; r++) m[r] = {VEC_N{SAT_MAX_WORD}};
    program_regs(m, 1'b0);
    send_vertex(mk_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_vertex(mk_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    wait_drained();
    for (int r = 0; r < VEC_N; r++) m[r] = {VEC_N{SAT_MIN_WORD}};
    program_regs(m, 1'b0);
    send_vertex(mk_vertex(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    wait_drained();
    // diagonal 0.5: odd negative inputs round down
    for (int r = 0; r < VEC_N; r++) m[r] = 64'h0080 << (COEF_W * r);
    program_regs(m, 1'b0);
    send_vertex(mk_vertex(-16'sd1, 16'sd1, -16'sd255, 16'sd3));
    wait_drained();
  endtask

  // divide stage: ordinary, zero w, tiny w, negative w, quotient overflow
  task automatic test_divide_cases();
    matrix_t m;
    for (int r = 0; r < VEC_N; r++) m[r] = COEF_RST[r];
    program_regs(m, 1'b1);
    send_vertex(mk_vertex(16'sh0200, 16'sh0100, -16'sh0300, 16'sh0100));
    send_vertex(mk_vertex(16'sh0200, 16'sh0100, 16'sh0300, 16'sh0000));
    send_vertex(mk_vertex(16'sh7fff, -16'sh0001, 16'sh0000, 16'sh0001));
    send_vertex(mk_vertex(16'sh0400, -16'sh0400, 16'sh0080, -16'sh0100));
    send_vertex(mk_vertex(16'sh8000, 16'sh0001, 16'sh0000, -16'sh0001));
    send_vertex(mk_vertex(16'sh8000, 16'sh7fff, 16'sh0100, 16'sh8000));
    wait_drained();
    // zero w together with clipping in the multiply stage
    m[0] = pack_row(SAT_MAX_WORD, '0, '0, '0);
    program_regs(m, 1'b1);
    send_vertex(mk_vertex(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000));
    wait_drained();
    // perspective projection
    program_regs(build_matrix(MAT_PERSPECTIVE), 1'b1);
    send_vertex(mk_vertex(16'sh0300, -16'sh0200, 16'sh0800, 16'sh0100));
    send_vertex(mk_vertex(-16'sh1000, 16'sh0040, -16'sh0400, 16'sh0100));
    wait_drained();
  endtask

  // unused indexes are ignored; only bit 0 of divide_mode counts
  task automatic test_register_decode();
    for (int i = CFG_UNUSED_FIRST; i <= CFG_UNUSED_LAST; i++)
      write_reg(CFG_IDX_W'(i), '1);
    write_reg(CFG_DIVIDE_MODE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
    cfg_release();
    send_vertex(mk_vertex(16'sh0300, -16'sh0200, 16'sh0800, 16'sh0000));
    wait_drained();
    write_reg(CFG_DIVIDE_MODE, {1'b1, {(CFG_DATA_W-2){1'b0}}, 1'b1});
    cfg_release();
    send_vertex(mk_vertex(16'sh0300, -16'sh0200, 16'sh0800, 16'sh0100));
    wait_drained();
  endtask

  // random vertices across a sequence of matrix settings
  task automatic test_random_streams();
    matrix_style_t plan [8] = '{MAT_SMALL, MAT_PERSPECTIVE, MAT_FULL, MAT_IDENTITY,
                                MAT_SMALL, MAT_ZERO, MAT_MAX, MAT_PERSPECTIVE};
    for (int p = 0; p < 8; p++) begin
      program_regs(build_matrix(plan[p]), (p % 2 == 1) || (p == 4));
      // every third phase runs without any idling
      in_idle_en   = (p % 3 != 2);
      out_stall_en = (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_vertex(rand_vertex());
      wait_drained();
    end
  endtask

  // receiver holds off long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    program_regs(build_matrix(MAT_SMALL), 1'b1);
    in_idle_en       = 1'b0;
    out_stall_en     = 1'b0;
    long_hold_cycles = 80;
    for (int i = 0; i < 40; i++) send_vertex(rand_vertex());
    wait_drained();
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_steady_stream();
    program_regs(build_matrix(MAT_FULL), 1'b0);
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
    for (int i = 0; i < 50; i++) send_vertex(rand_vertex());
    in_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_x  = '0;
    in_ch.in_y  = '0;
    in_ch.in_z  = '0;
    in_ch.in_w  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_COEF_ROW0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_extremes();
    test_multiply_saturation();
    test_divide_cases();
    test_register_decode();
    test_random_streams();
    test_backpressure();
    test_steady_stream();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d vertices, %0d words checked, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("clipped words: %0d, zero-w words: %0d, mismatches: %0d",
             clip_seen, zero_w_seen, error_count);
    if (error_count == 0)
      $display("[vertex_matrix_transform] OK");
    else
      $display("[vertex_matrix_transform] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("%0t: timeout with %0d words still outstanding", $time, pending_results.size());
    $display("[vertex_matrix_transform] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: vertex_matrix_transform.f
hdl/vmt_pkg.sv
hdl/vmt_stream_if.sv
hdl/vmt_div_lane.sv
hdl/vertex_matrix_transform.sv
dv/testbench.sv
